### sv/dsa_pkg.sv
// Shared types and codes for the shared-array double stack.
// No dependencies; used by every other file of the block but dsa_ram.
package dsa_pkg;

    // Width of one stored word
    localparam int WORD_W = 64;

    // Entries of the command queue between front and back
    localparam int Q_DEPTH = 2;

    // Result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Item kinds
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // Memory operation of a queued command
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Classified item: memory op plus the result already known at the front
    typedef struct packed {
        logic [1:0] op;
        logic [1:0] status;
        logic       lower_empty;
        logic       upper_empty;
        logic       all_full;
    } meta_t;

endpackage

### sv/dsa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module dsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/dsa_front.sv
// Front end: keeps both stack counts, classifies each item into a status,
// a memory slot and the flags after the step. Depends on dsa_pkg.
module dsa_front #(
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     fire,
    input  logic                     kind,
    input  logic                     stack_sel,
    output dsa_pkg::meta_t           meta,
    output logic [$clog2(DEPTH)-1:0] addr
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW:0] DEPTH_W = (CW + 1)'(DEPTH);

    logic [CW-1:0] lower_count_reg, lower_count_next;
    logic [CW-1:0] upper_count_reg, upper_count_next;
    logic [CW:0]   sum_now;
    logic [CW:0]   sum_next;
    logic [CW:0]   slot;
    logic          full_now;

    assign sum_now  = {1'b0, lower_count_reg} + {1'b0, upper_count_reg};
    assign full_now = (sum_now >= DEPTH_W);

    // Classify the item
    always_comb
    begin
        lower_count_next = lower_count_reg;
        upper_count_next = upper_count_reg;
        slot             = '0;
        meta.op          = dsa_pkg::OP_NONE;
        meta.status      = dsa_pkg::ST_DONE;
        if (kind == dsa_pkg::KIND_PUSH)
        begin
            if (full_now)
            begin
                meta.status = dsa_pkg::ST_FULL;
            end
            else if (!stack_sel)
            begin
                meta.op          = dsa_pkg::OP_WRITE;
                slot             = {1'b0, lower_count_reg};
                lower_count_next = lower_count_reg + 1'b1;
            end
            else
            begin
                meta.op          = dsa_pkg::OP_WRITE;
                slot             = DEPTH_W - (CW + 1)'(1) - {1'b0, upper_count_reg};
                upper_count_next = upper_count_reg + 1'b1;
            end
        end
        else
        begin
            if (!stack_sel)
            begin
                if (lower_count_reg == '0)
                begin
                    meta.status = dsa_pkg::ST_EMPTY;
                end
                else
                begin
                    meta.op          = dsa_pkg::OP_READ;
                    slot             = {1'b0, lower_count_reg} - (CW + 1)'(1);
                    lower_count_next = lower_count_reg - 1'b1;
                end
            end
            else
            begin
                if (upper_count_reg == '0)
                begin
                    meta.status = dsa_pkg::ST_EMPTY;
                end
                else
                begin
                    meta.op          = dsa_pkg::OP_READ;
                    slot             = DEPTH_W - {1'b0, upper_count_reg};
                    upper_count_next = upper_count_reg - 1'b1;
                end
            end
        end

        // Flags after the step
        sum_next         = {1'b0, lower_count_next} + {1'b0, upper_count_next};
        meta.lower_empty = (lower_count_next == '0);
        meta.upper_empty = (upper_count_next == '0);
        meta.all_full    = (sum_next >= DEPTH_W);
    end

    assign addr = slot[AW-1:0];

    // Count registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_count_reg <= '0;
            upper_count_reg <= '0;
        end
        else if (fire)
        begin
            lower_count_reg <= lower_count_next;
            upper_count_reg <= upper_count_next;
        end
    end

endmodule

### sv/dsa_queue.sv
// Short command queue between front and back, flip-flop storage.
// Depends on dsa_pkg for its depth.
module dsa_queue #(
    parameter int WIDTH = 80
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] head
);

    localparam int QAW = (dsa_pkg::Q_DEPTH > 1) ? $clog2(dsa_pkg::Q_DEPTH) : 1;
    localparam logic [QAW-1:0] LAST = QAW'(dsa_pkg::Q_DEPTH - 1);
    localparam int CNTW = $clog2(dsa_pkg::Q_DEPTH + 1);

    logic [WIDTH-1:0] slots_reg [dsa_pkg::Q_DEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;

    assign full      = (count_reg == CNTW'(dsa_pkg::Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slots_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### sv/dsa_back.sv
// Back end: runs queued memory commands in order against the word store
// and registers each result. Depends on dsa_pkg and dsa_ram.
module dsa_back #(
    parameter int DEPTH = 128
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  dsa_pkg::meta_t              q_meta,
    input  logic [$clog2(DEPTH)-1:0]    q_addr,
    input  logic [dsa_pkg::WORD_W-1:0]  q_word,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  status,
    output logic [dsa_pkg::WORD_W-1:0]  pop_word,
    output logic                        lower_empty,
    output logic                        upper_empty,
    output logic                        all_full
);

    logic                       p_valid_reg, p_valid_next;
    dsa_pkg::meta_t             p_meta_reg;
    logic                       out_valid_reg, out_valid_next;
    dsa_pkg::meta_t             out_meta_reg;
    logic [dsa_pkg::WORD_W-1:0] out_word_reg;
    logic [dsa_pkg::WORD_W-1:0] rdata;
    logic                       advance;
    logic                       ram_we;
    logic                       ram_re;

    // Issue stage handshake
    assign advance = p_valid_reg && (!out_valid_reg || out_ready);
    assign q_pop   = q_valid && (!p_valid_reg || advance);
    assign ram_we  = q_pop && (q_meta.op == dsa_pkg::OP_WRITE);
    assign ram_re  = q_pop && (q_meta.op == dsa_pkg::OP_READ);

    dsa_ram #(
        .WIDTH (dsa_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (q_addr),
        .wdata (q_word),
        .re    (ram_re),
        .raddr (q_addr),
        .rdata (rdata)
    );

    // Valid bits of the two stages
    always_comb
    begin
        p_valid_next = p_valid_reg;
        if (q_pop)
        begin
            p_valid_next = 1'b1;
        end
        else if (advance)
        begin
            p_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg   <= p_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            p_meta_reg <= q_meta;
        end
        if (advance)
        begin
            out_meta_reg <= p_meta_reg;
            out_word_reg <= (p_meta_reg.op == dsa_pkg::OP_READ) ? rdata : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_meta_reg.status;
    assign pop_word    = out_word_reg;
    assign lower_empty = out_meta_reg.lower_empty;
    assign upper_empty = out_meta_reg.upper_empty;
    assign all_full    = out_meta_reg.all_full;

endmodule

### sv/shared_array_double_stack.sv
// Top level of the shared-array double stack: front, command queue, back.
// Depends on dsa_pkg, dsa_front, dsa_queue, dsa_back (and dsa_ram below it).
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   in      | in_valid / in_ready  | kind, stack_sel, push_word
//   out     | out_valid / out_ready| status, pop_word, lower_empty,
//           |                      | upper_empty, all_full
//
// One item per cycle sustained while the output is not stalled; the back
// end issues at most one memory access per cycle into the word store's
// single write or read port. From input accept to result valid an item
// passes the queue, the issue stage with the memory access, then the output
// register. Reset clears the counts, queue and stage valids; the word store
// is not cleared. A stalled output fills the queue, then in_ready drops.
module shared_array_double_stack #(
    parameter int DEPTH = 128
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       kind,
    input  logic                       stack_sel,
    input  logic [dsa_pkg::WORD_W-1:0] push_word,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 status,
    output logic [dsa_pkg::WORD_W-1:0] pop_word,
    output logic                       lower_empty,
    output logic                       upper_empty,
    output logic                       all_full
);

    localparam int AW = $clog2(DEPTH);
    localparam int MW = $bits(dsa_pkg::meta_t);
    localparam int QW = MW + AW + dsa_pkg::WORD_W;

    dsa_pkg::meta_t             f_meta;
    logic [AW-1:0]              f_addr;
    logic                       q_full;
    logic                       q_not_empty;
    logic                       q_pop;
    logic [QW-1:0]              q_head;
    dsa_pkg::meta_t             h_meta;
    logic [AW-1:0]              h_addr;
    logic [dsa_pkg::WORD_W-1:0] h_word;
    logic                       fire;

    assign in_ready = !q_full;
    assign fire     = in_valid && in_ready;

    dsa_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .kind      (kind),
        .stack_sel (stack_sel),
        .meta      (f_meta),
        .addr      (f_addr)
    );

    dsa_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .push_data ({f_meta, f_addr, push_word}),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // Unpack the queue head
    assign h_meta = q_head[QW-1 -: MW];
    assign h_addr = q_head[dsa_pkg::WORD_W +: AW];
    assign h_word = q_head[dsa_pkg::WORD_W-1:0];

    dsa_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_not_empty),
        .q_meta      (h_meta),
        .q_addr      (h_addr),
        .q_word      (h_word),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .pop_word    (pop_word),
        .lower_empty (lower_empty),
        .upper_empty (upper_empty),
        .all_full    (all_full)
    );

endmodule

### sv/dsa_checker.sv
// Port-level checks for the shared-array double stack, bound to the top.
// Depends on dsa_pkg and shared_array_double_stack.
module dsa_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [1:0]                 status,
    input logic [dsa_pkg::WORD_W-1:0] pop_word,
    input logic                       lower_empty,
    input logic                       upper_empty,
    input logic                       all_full
);

    // A held result keeps its status
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("result changed while stalled");

    // A refused push only happens when the stacks have met
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == dsa_pkg::ST_FULL |-> all_full)
        else $error("push refused without full flag");

    // A refused pop leaves some stack empty
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == dsa_pkg::ST_EMPTY |-> lower_empty || upper_empty)
        else $error("pop refused with both stacks holding words");

    // Refusals carry no word
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != dsa_pkg::ST_DONE |-> pop_word == '0)
        else $error("refused item carries a word");

    // Both stacks empty and full at once is impossible
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(lower_empty && upper_empty && all_full))
        else $error("inconsistent flags");

endmodule

bind shared_array_double_stack dsa_checker u_dsa_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .pop_word    (pop_word),
    .lower_empty (lower_empty),
    .upper_empty (upper_empty),
    .all_full    (all_full)
);

### test/shared_array_double_stack_test.sv
// Testbench for shared_array_double_stack: directed table, then fill/drain shaped traffic.
// Depends on dsa_pkg and the shared_array_double_stack RTL; checks every result against the
// table's expected value or a behavioral model of the two stacks kept in this file.
module shared_array_double_stack_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH    = 128;
    localparam int RANDOM_ITEMS   = 1600;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    // Fill/drain shaping of the random traffic
    localparam int MODE_FILL     = 0;
    localparam int MODE_BALANCED = 1;
    localparam int MODE_DRAIN    = 2;

    typedef struct packed {
        logic [1:0]                 status;
        logic [dsa_pkg::WORD_W-1:0] pop_word;
        logic                       lower_empty;
        logic                       upper_empty;
        logic                       all_full;
    } stack_result_t;

    typedef struct packed {
        logic                       kind;
        logic                       sel;
        logic [dsa_pkg::WORD_W-1:0] word;
        logic                       fixed;
        stack_result_t              want;
    } dir_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic                       kind;
    logic                       stack_sel;
    logic [dsa_pkg::WORD_W-1:0] push_word;
    logic                       out_valid;
    logic                       out_ready;
    logic [1:0]                 status;
    logic [dsa_pkg::WORD_W-1:0] pop_word;
    logic                       lower_empty;
    logic                       upper_empty;
    logic                       all_full;

    // Typed expectation that travels with the item currently on the input
    logic                       item_fixed;
    stack_result_t              item_want;

    // Model state of the two stacks
    logic [dsa_pkg::WORD_W-1:0] shadow_mem [STACK_DEPTH];
    int                         lower_cnt;
    int                         upper_cnt;

    stack_result_t              pending_results [$];
    int                         err_count;
    int                         quiet_cycles;
    int                         in_idle_pct;
    int                         out_stall_pct;

    dir_row_t                   dir_rows [18];

    shared_array_double_stack #(
        .DEPTH(STACK_DEPTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .stack_sel  (stack_sel),
        .push_word  (push_word),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .pop_word   (pop_word),
        .lower_empty(lower_empty),
        .upper_empty(upper_empty),
        .all_full   (all_full)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Advance the stack model by one item and return the result it gives
    function automatic stack_result_t stack_step(logic k, logic s,
                                                 logic [dsa_pkg::WORD_W-1:0] w);
        stack_result_t r;
        r = '0;
        r.status = dsa_pkg::ST_DONE;
        if (k == dsa_pkg::KIND_PUSH)
        begin
            if (lower_cnt + upper_cnt >= STACK_DEPTH)
                r.status = dsa_pkg::ST_FULL;
            else if (s == 1'b0)
            begin
                shadow_mem[lower_cnt] = w;
                lower_cnt++;
            end
            else
            begin
                upper_cnt++;
                shadow_mem[STACK_DEPTH - upper_cnt] = w;
            end
        end
        else if (s == 1'b0)
        begin
            if (lower_cnt == 0)
                r.status = dsa_pkg::ST_EMPTY;
            else
            begin
                r.pop_word = shadow_mem[lower_cnt - 1];
                lower_cnt--;
            end
        end
        else
        begin
            if (upper_cnt == 0)
                r.status = dsa_pkg::ST_EMPTY;
            else
            begin
                r.pop_word = shadow_mem[STACK_DEPTH - upper_cnt];
                upper_cnt--;
            end
        end
        r.lower_empty = (lower_cnt == 0);
        r.upper_empty = (upper_cnt == 0);
        r.all_full    = (lower_cnt + upper_cnt >= STACK_DEPTH);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [dsa_pkg::WORD_W-1:0] got,
                                   logic [dsa_pkg::WORD_W-1:0] want);
        $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
        err_count++;
    endtask

    // Compare the result on the output against the oldest pending one
    task automatic check_result();
        stack_result_t want;
        if (pending_results.size() == 0)
            report_mismatch("result with nothing pending", pop_word, '0);
        else
        begin
            want = pending_results.pop_front();
            if (status !== want.status)
                report_mismatch("status", status, want.status);
            if (pop_word !== want.pop_word)
                report_mismatch("pop_word", pop_word, want.pop_word);
            if (lower_empty !== want.lower_empty)
                report_mismatch("lower_empty", lower_empty, want.lower_empty);
            if (upper_empty !== want.upper_empty)
                report_mismatch("upper_empty", upper_empty, want.upper_empty);
            if (all_full !== want.all_full)
                report_mismatch("all_full", all_full, want.all_full);
        end
    endtask

    // Edge monitor: log accepted items, check results, watch for a hang
    always @(posedge clk)
    begin : monitor
        stack_result_t predicted;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predicted = stack_step(kind, stack_sel, push_word);
                pending_results.push_back(item_fixed ? item_want : predicted);
            end
            if (out_valid && out_ready)
                check_result();
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t ns: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Receiver back-pressure
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= out_stall_pct);

    // Present one item at a falling edge and hold it until accepted
    task automatic send_item(logic k, logic s, logic [dsa_pkg::WORD_W-1:0] w, logic fixed,
                             stack_result_t want);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        kind       <= k;
        stack_sel  <= s;
        push_word  <= w;
        item_fixed <= fixed;
        item_want  <= want;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [dsa_pkg::WORD_W-1:0] rand_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Stimulus
    initial
    begin : stimulus
        int mode;
        int seg_left;
        int push_pct;
        int lower_pct;
        int phase;
        logic k;
        logic s;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        kind          = dsa_pkg::KIND_PUSH;
        stack_sel     = 1'b0;
        push_word     = '0;
        item_fixed    = 1'b0;
        item_want     = '0;
        in_idle_pct   = 0;
        out_stall_pct = 0;
        err_count     = 0;
        quiet_cycles  = 0;
        lower_cnt     = 0;
        upper_cnt     = 0;

        // Directed rows: empty pops after reset, extreme words, LIFO order,
        // push_word ignored on a pop. Unflagged rows go to the model.
        dir_rows = '{
            '{dsa_pkg::KIND_POP,  1'b0, 64'h0, 1'b1,
              '{dsa_pkg::ST_EMPTY, 64'h0, 1'b1, 1'b1, 1'b0}},
            '{dsa_pkg::KIND_POP,  1'b1, 64'h0, 1'b1,
              '{dsa_pkg::ST_EMPTY, 64'h0, 1'b1, 1'b1, 1'b0}},
            '{dsa_pkg::KIND_PUSH, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
              '{dsa_pkg::ST_DONE, 64'h0, 1'b0, 1'b1, 1'b0}},
            '{dsa_pkg::KIND_PUSH, 1'b1, 64'h0, 1'b1,
              '{dsa_pkg::ST_DONE, 64'h0, 1'b0, 1'b0, 1'b0}},
            '{dsa_pkg::KIND_PUSH, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1,
              '{dsa_pkg::ST_DONE, 64'h0, 1'b0, 1'b0, 1'b0}},
            '{dsa_pkg::KIND_PUSH, 1'b0, 64'h5555_5555_5555_5555, 1'b1,
              '{dsa_pkg::ST_DONE, 64'h0, 1'b0, 1'b0, 1'b0}},
            '{dsa_pkg::KIND_POP,  1'b0, 64'h0, 1'b1,
              '{dsa_pkg::ST_DONE, 64'h5555_5555_5555_5555, 1'b0, 1'b0, 1'b0}},
            '{dsa_pkg::KIND_POP,  1'b0, 64'h0, 1'b1,
              '{dsa_pkg::ST_DONE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0}},
            '{dsa_pkg::KIND_POP,  1'b0, 64'h0, 1'b1,
              '{dsa_pkg::ST_EMPTY, 64'h0, 1'b1, 1'b0, 1'b0}},
            '{dsa_pkg::KIND_POP,  1'b1, 64'h0, 1'b1,
              '{dsa_pkg::ST_DONE, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0, 1'b0}},
            '{dsa_pkg::KIND_POP,  1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
              '{dsa_pkg::ST_DONE, 64'h0, 1'b1, 1'b1, 1'b0}},
            '{dsa_pkg::KIND_POP,  1'b1, 64'h0, 1'b1,
              '{dsa_pkg::ST_EMPTY, 64'h0, 1'b1, 1'b1, 1'b0}},
            '{dsa_pkg::KIND_PUSH, 1'b0, 64'h8000_0000_0000_0001, 1'b1,
              '{dsa_pkg::ST_DONE, 64'h0, 1'b0, 1'b1, 1'b0}},
            '{dsa_pkg::KIND_POP,  1'b0, 64'h1234_5678_9ABC_DEF0, 1'b1,
              '{dsa_pkg::ST_DONE, 64'h8000_0000_0000_0001, 1'b1, 1'b1, 1'b0}},
            '{dsa_pkg::KIND_PUSH, 1'b1, 64'h0000_0000_0000_0001, 1'b0, '0},
            '{dsa_pkg::KIND_PUSH, 1'b0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, '0},
            '{dsa_pkg::KIND_POP,  1'b1, 64'h0, 1'b0, '0},
            '{dsa_pkg::KIND_POP,  1'b0, 64'h0, 1'b0, '0}
        };

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
            send_item(dir_rows[i].kind, dir_rows[i].sel, dir_rows[i].word,
                      dir_rows[i].fixed, dir_rows[i].want);

        // Random part: segments alternate fill, balanced and drain so both
        // the full and the empty refusals come up repeatedly.
        mode     = MODE_FILL;
        seg_left = 0;
        push_pct  = 50;
        lower_pct = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // Idle phases: none, sender gaps, receiver stalls, both
            phase = n * 4 / RANDOM_ITEMS;
            case (phase)
                0:       begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1:       begin in_idle_pct = 60; out_stall_pct = 0;  end
                2:       begin in_idle_pct = 0;  out_stall_pct = 60; end
                default: begin in_idle_pct = 23; out_stall_pct = 23; end
            endcase

            if (seg_left == 0)
            begin
                seg_left = $urandom_range(260, 180);
                case (mode)
                    MODE_FILL:     push_pct = 90;
                    MODE_BALANCED: push_pct = 50;
                    default:       push_pct = 10;
                endcase
                case ($urandom_range(2))
                    0:       lower_pct = 50;
                    1:       lower_pct = 90;
                    default: lower_pct = 10;
                endcase
                mode = (mode + 1) % 3;
            end
            seg_left--;

            k = ($urandom_range(99) < push_pct) ? dsa_pkg::KIND_PUSH : dsa_pkg::KIND_POP;
            s = ($urandom_range(99) < lower_pct) ? 1'b0 : 1'b1;
            send_item(k, s, rand_word(), 1'b0, '0);
        end

        // Wind down: let every pending result arrive, then watch a little longer
        in_valid      <= 1'b0;
        in_idle_pct   = 0;
        out_stall_pct = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
